/* rtl/size_class_block_pool_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
// Uses the including module's clk and rst_n; no other dependencies.
`ifndef SIZE_CLASS_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SCBPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCBPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/scbpa_pkg.sv */
// Shared widths, codes and helpers for the block pool allocator.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package scbpa_pkg;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int HDR_W   = 8;
  localparam int LOG_W   = 5;
  localparam int CNT_W   = 6;
  localparam int NPOOL   = 3;
  localparam int POOL_IW = 2;
  localparam int BYTES_W = 17;   // block bytes, up to 2^16
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  typedef logic [1:0]         req_type_t;
  typedef logic [1:0]         status_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [HDR_W-1:0]   hdr_t;
  typedef logic [LOG_W-1:0]   log_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [BYTES_W-1:0] bytes_t;
  typedef logic [2:0]         reg_idx_t;
  typedef logic [POOL_IW-1:0] pool_idx_t;

  localparam req_type_t REQ_ALLOC = 2'd0;
  localparam req_type_t REQ_FREE  = 2'd1;
  localparam req_type_t REQ_INIT  = 2'd2;

  localparam status_t STAT_OK      = 2'd0;
  localparam status_t STAT_EMPTY   = 2'd1;
  localparam status_t STAT_NOFIT   = 2'd2;
  localparam status_t STAT_BADADDR = 2'd3;

  localparam reg_idx_t REG_AREA_BASE    = 3'd0;
  localparam reg_idx_t REG_HEADER_BYTES = 3'd1;
  localparam reg_idx_t REG_SMALL_LOG2   = 3'd2;
  localparam reg_idx_t REG_MIDDLE_LOG2  = 3'd3;
  localparam reg_idx_t REG_LARGE_LOG2   = 3'd4;
  localparam reg_idx_t REG_SMALL_COUNT  = 3'd5;
  localparam reg_idx_t REG_MIDDLE_COUNT = 3'd6;
  localparam reg_idx_t REG_LARGE_COUNT  = 3'd7;

  localparam addr_t RST_AREA_BASE    = 32'd0;
  localparam hdr_t  RST_HEADER_BYTES = 8'd8;
  localparam log_t  RST_SMALL_LOG2   = 5'd4;
  localparam log_t  RST_MIDDLE_LOG2  = 5'd5;
  localparam log_t  RST_LARGE_LOG2   = 5'd6;
  localparam cnt_t  RST_SMALL_COUNT  = 6'd8;
  localparam cnt_t  RST_MIDDLE_COUNT = 6'd8;
  localparam cnt_t  RST_LARGE_COUNT  = 6'd6;

  localparam log_t LOG_MIN = 5'd2;
  localparam log_t LOG_MAX = 5'd16;

  function automatic log_t clamp_log2(log_t v);
    log_t r;
    if (v < LOG_MIN) begin
      r = LOG_MIN;
    end else if (v > LOG_MAX) begin
      r = LOG_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/scbpa_if.sv */
// Request and response channel interfaces (valid/ready plus payload).
// Depends on scbpa_pkg.
`timescale 1ns / 1ps

interface scbpa_req_if;
  import scbpa_pkg::*;
  logic      valid;
  logic      ready;
  req_type_t req_type;
  size_t     req_size;
  addr_t     block_address;

  modport source (output valid, req_type, req_size, block_address, input ready);
  modport sink   (input valid, req_type, req_size, block_address, output ready);
endinterface

interface scbpa_rsp_if;
  import scbpa_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  addr_t   granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

/* rtl/scbpa_cfg.sv */
// APB-style register file plus registered pool geometry (clipped counts,
// first indices, spans, bases, usable bytes). Depends on scbpa_pkg.
`timescale 1ns / 1ps

module scbpa_cfg #(
  parameter  int MAX_BLOCKS = 32,
  parameter  int POOL_COUNT = 3,
  localparam int IW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              psel,
  input  logic                                              penable,
  input  logic                                              pwrite,
  input  logic [scbpa_pkg::CFG_AW-1:0]                      paddr,
  input  logic [scbpa_pkg::CFG_DW-1:0]                      pwdata,
  output logic [scbpa_pkg::CFG_DW-1:0]                      prdata,
  output logic                                              pready,
  output logic                                              busy,
  output scbpa_pkg::hdr_t                                   header_bytes,
  output logic [scbpa_pkg::NPOOL-1:0][IW-1:0]               pool_first,
  output logic [scbpa_pkg::NPOOL-1:0][IW-1:0]               pool_cnt,
  output logic [scbpa_pkg::NPOOL-1:0][scbpa_pkg::LOG_W-1:0] pool_log,
  output logic [scbpa_pkg::NPOOL-1:0][scbpa_pkg::ADDR_W-1:0] pool_span,
  output logic [scbpa_pkg::NPOOL-1:0][scbpa_pkg::ADDR_W-1:0] pool_base,
  output logic [scbpa_pkg::NPOOL-1:0][scbpa_pkg::BYTES_W-1:0] pool_avail,
  output logic [scbpa_pkg::NPOOL-1:0]                       pool_hdr_ok,
  output logic [IW-1:0]                                     total_blocks
);
  import scbpa_pkg::*;

  localparam int CW = (IW > CNT_W) ? IW : CNT_W;

  addr_t    area_base_r;
  hdr_t     header_bytes_r;
  log_t     log_r [NPOOL];
  cnt_t     cnt_r [NPOOL];
  logic [1:0] settle_r;

  logic     wr_en;
  reg_idx_t ridx;

  assign wr_en  = psel & penable & pwrite;
  assign ridx   = paddr[CFG_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_base_r    <= RST_AREA_BASE;
      header_bytes_r <= RST_HEADER_BYTES;
      log_r[0]       <= RST_SMALL_LOG2;
      log_r[1]       <= RST_MIDDLE_LOG2;
      log_r[2]       <= RST_LARGE_LOG2;
      cnt_r[0]       <= RST_SMALL_COUNT;
      cnt_r[1]       <= RST_MIDDLE_COUNT;
      cnt_r[2]       <= RST_LARGE_COUNT;
    end else if (wr_en) begin
      unique case (ridx)
        REG_AREA_BASE:    area_base_r    <= pwdata[ADDR_W-1:0];
        REG_HEADER_BYTES: header_bytes_r <= pwdata[HDR_W-1:0];
        REG_SMALL_LOG2:   log_r[0]       <= pwdata[LOG_W-1:0];
        REG_MIDDLE_LOG2:  log_r[1]       <= pwdata[LOG_W-1:0];
        REG_LARGE_LOG2:   log_r[2]       <= pwdata[LOG_W-1:0];
        REG_SMALL_COUNT:  cnt_r[0]       <= pwdata[CNT_W-1:0];
        REG_MIDDLE_COUNT: cnt_r[1]       <= pwdata[CNT_W-1:0];
        REG_LARGE_COUNT:  cnt_r[2]       <= pwdata[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_AREA_BASE:    prdata = CFG_DW'(area_base_r);
      REG_HEADER_BYTES: prdata = CFG_DW'(header_bytes_r);
      REG_SMALL_LOG2:   prdata = CFG_DW'(log_r[0]);
      REG_MIDDLE_LOG2:  prdata = CFG_DW'(log_r[1]);
      REG_LARGE_LOG2:   prdata = CFG_DW'(log_r[2]);
      REG_SMALL_COUNT:  prdata = CFG_DW'(cnt_r[0]);
      REG_MIDDLE_COUNT: prdata = CFG_DW'(cnt_r[1]);
      REG_LARGE_COUNT:  prdata = CFG_DW'(cnt_r[2]);
    endcase
  end

  // geometry is two register stages behind the config regs; hold off requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 2'd2;
    end else if (wr_en) begin
      settle_r <= 2'd2;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end
  assign busy = (settle_r != 2'd0);

  // stage 1: clip counts against remaining capacity, running first index
  logic [CW-1:0] used, room, craw, cc;
  logic [NPOOL-1:0][IW-1:0]     first_c, cnt_c;
  logic [NPOOL-1:0][LOG_W-1:0]  log_c;
  logic [NPOOL-1:0][ADDR_W-1:0] span_c;
  logic [IW-1:0]                total_c;

  always_comb begin
    used = '0;
    room = '0;
    craw = '0;
    cc   = '0;
    for (int p = 0; p < NPOOL; p++) begin
      craw       = (p < POOL_COUNT) ? CW'(cnt_r[p]) : '0;
      room       = CW'(MAX_BLOCKS) - used;
      cc         = (craw > room) ? room : craw;
      first_c[p] = IW'(used);
      cnt_c[p]   = IW'(cc);
      log_c[p]   = clamp_log2(log_r[p]);
      span_c[p]  = ADDR_W'(cc) << log_c[p];
      used       = used + cc;
    end
    total_c = IW'(used);
  end

  always_ff @(posedge clk) begin
    pool_first   <= first_c;
    pool_cnt     <= cnt_c;
    pool_log     <= log_c;
    pool_span    <= span_c;
    total_blocks <= total_c;
  end

  // stage 2: pool bases and usable bytes per block
  bytes_t blk_bytes [NPOOL];
  always_comb begin
    for (int p = 0; p < NPOOL; p++) begin
      blk_bytes[p] = BYTES_W'(1) << pool_log[p];
    end
  end

  always_ff @(posedge clk) begin
    pool_base[0] <= area_base_r;
    pool_base[1] <= area_base_r + pool_span[0];
    pool_base[2] <= area_base_r + pool_span[0] + pool_span[1];
    for (int p = 0; p < NPOOL; p++) begin
      pool_avail[p]  <= blk_bytes[p] - BYTES_W'(header_bytes_r);
      pool_hdr_ok[p] <= (blk_bytes[p] >= BYTES_W'(header_bytes_r));
    end
  end

  assign header_bytes = header_bytes_r;

endmodule

/* rtl/size_class_block_pool_allocator.sv */
// Alloc/free: the accepted request moves to its state, which loads the result when the
// output is free; no new request is taken before that. Alloc reads the head's next link
// from the registered-read link memory, then pops. Init: one link entry written per cycle
// unless config is busy (the last waits for a free output), then the result. Reset (sync,
// active low) runs the same sweep; ready is low until it ends and while config is busy.
`timescale 1ns / 1ps
`include "size_class_block_pool_allocator_macros.svh"

module size_class_block_pool_allocator #(
  parameter  int MAX_BLOCKS = 32,
  parameter  int POOL_COUNT = 3,
  localparam int IW = $clog2(MAX_BLOCKS + 1),
  localparam int AW = $clog2(MAX_BLOCKS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  scbpa_req_if.sink                    in_req,
  scbpa_rsp_if.source                  out_rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scbpa_pkg::CFG_AW-1:0] paddr,
  input  logic [scbpa_pkg::CFG_DW-1:0] pwdata,
  output logic [scbpa_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import scbpa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_NOP   = 3'd4;

  localparam logic [IW-1:0] END_MARK = IW'(MAX_BLOCKS);
  localparam logic [AW-1:0] K_LAST   = AW'(MAX_BLOCKS - 1);

  // geometry from the register block
  logic                          cfg_busy;
  hdr_t                          hdr;
  logic [NPOOL-1:0][IW-1:0]      g_first, g_cnt;
  logic [NPOOL-1:0][LOG_W-1:0]   g_log;
  logic [NPOOL-1:0][ADDR_W-1:0]  g_span, g_base;
  logic [NPOOL-1:0][BYTES_W-1:0] g_avail;
  logic [NPOOL-1:0]              g_hdr_ok;
  logic [IW-1:0]                 g_total;

  scbpa_cfg #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .POOL_COUNT (POOL_COUNT)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .busy         (cfg_busy),
    .header_bytes (hdr),
    .pool_first   (g_first),
    .pool_cnt     (g_cnt),
    .pool_log     (g_log),
    .pool_span    (g_span),
    .pool_base    (g_base),
    .pool_avail   (g_avail),
    .pool_hdr_ok  (g_hdr_ok),
    .total_blocks (g_total)
  );

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] head_r [NPOOL];
  pool_idx_t     pool_r, pool_nxt;
  status_t       stat_r, stat_nxt;
  addr_t         offs_r, offs_nxt;
  addr_t         start_r;
  logic [AW-1:0] k_r, k_nxt;
  logic          init_reply_r, init_reply_nxt;
  logic          out_valid_r;
  status_t       out_status_r;
  addr_t         out_addr_r;

  // link memory: one write port, one registered read port
  logic [IW-1:0] link_mem [MAX_BLOCKS];
  logic [IW-1:0] rd_data_r;
  logic          rd_en, mem_we;
  logic [AW-1:0] rd_addr, mem_waddr;
  logic [IW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[rd_addr];
    end
  end

  logic accept, out_free;
  assign in_req.ready = (state_r == S_IDLE) && !cfg_busy;
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // allocate decode straight from the request word
  logic [NPOOL-1:0] fit;
  logic             any_fit, head_empty;
  pool_idx_t        fit_sel;
  logic [IW-1:0]    sel_head;

  always_comb begin
    any_fit = 1'b0;
    fit_sel = '0;
    for (int p = NPOOL - 1; p >= 0; p--) begin
      fit[p] = (p < POOL_COUNT) && g_hdr_ok[p] &&
               (BYTES_W'(in_req.req_size) <= g_avail[p]);
      if (fit[p]) begin
        any_fit = 1'b1;
        fit_sel = POOL_IW'(p);
      end
    end
    sel_head   = head_r[fit_sel];
    head_empty = (sel_head >= END_MARK);
  end

  assign rd_en   = accept && (in_req.req_type == REQ_ALLOC) && any_fit && !head_empty;
  assign rd_addr = sel_head[AW-1:0];

  // free lookup: range and alignment match per pool, lowest-numbered pool wins
  addr_t     off [NPOOL];
  addr_t     amask [NPOOL];
  logic      free_hit;
  pool_idx_t free_sel;
  logic [IW-1:0] free_idx;

  always_comb begin
    free_hit = 1'b0;
    free_sel = '0;
    free_idx = '0;
    for (int p = NPOOL - 1; p >= 0; p--) begin
      off[p]   = start_r - g_base[p];
      amask[p] = (ADDR_W'(1) << g_log[p]) - ADDR_W'(1);
      if ((g_cnt[p] != '0) && (off[p] < g_span[p]) && ((off[p] & amask[p]) == '0)) begin
        free_hit = 1'b1;
        free_sel = POOL_IW'(p);
        free_idx = g_first[p] + IW'(off[p] >> g_log[p]);
      end
    end
  end

  // init sweep: link to the next index unless it opens a pool or ends the area
  logic [IW-1:0] k_next_idx;
  logic          k_links;
  always_comb begin
    k_next_idx = IW'(k_r) + IW'(1);
    k_links    = (k_next_idx < g_total);
    for (int p = 1; p < NPOOL; p++) begin
      if (k_next_idx == g_first[p]) begin
        k_links = 1'b0;
      end
    end
  end

  // main sequencer
  logic      res_load;
  status_t   res_status;
  addr_t     res_addr;
  logic      head_we, heads_init;
  pool_idx_t head_sel;
  logic [IW-1:0] head_wdata;

  always_comb begin
    state_nxt      = state_r;
    pool_nxt       = pool_r;
    stat_nxt       = stat_r;
    offs_nxt       = offs_r;
    k_nxt          = k_r;
    init_reply_nxt = init_reply_r;
    res_load       = 1'b0;
    res_status     = STAT_OK;
    res_addr       = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = END_MARK;
    head_we        = 1'b0;
    heads_init     = 1'b0;
    head_sel       = '0;
    head_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pool_nxt = fit_sel;
          offs_nxt = ((ADDR_W'(sel_head) - ADDR_W'(g_first[fit_sel])) << g_log[fit_sel])
                     + ADDR_W'(hdr);
          if (!any_fit) begin
            stat_nxt = STAT_NOFIT;
          end else if (head_empty) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            stat_nxt = STAT_OK;
          end
          case (in_req.req_type)
            REQ_ALLOC: state_nxt = S_ALLOC;
            REQ_FREE:  state_nxt = S_FREE;
            REQ_INIT: begin
              state_nxt      = S_INIT;
              k_nxt          = '0;
              init_reply_nxt = 1'b1;
            end
            default:   state_nxt = S_NOP;
          endcase
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = stat_r;
          state_nxt  = S_IDLE;
          if (stat_r == STAT_OK) begin
            res_addr   = g_base[pool_r] + offs_r;
            head_we    = 1'b1;
            head_sel   = pool_r;
            head_wdata = rd_data_r;
            mem_we     = 1'b1;
            mem_waddr  = head_r[pool_r][AW-1:0];
            mem_wdata  = END_MARK;
          end
        end
      end
      S_FREE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = free_hit ? STAT_OK : STAT_BADADDR;
          state_nxt  = S_IDLE;
          if (free_hit) begin
            head_we    = 1'b1;
            head_sel   = free_sel;
            head_wdata = free_idx;
            mem_we     = 1'b1;
            mem_waddr  = free_idx[AW-1:0];
            mem_wdata  = head_r[free_sel];
          end
        end
      end
      S_INIT: begin
        if (!cfg_busy && ((k_r != K_LAST) || !init_reply_r || out_free)) begin
          mem_we    = 1'b1;
          mem_waddr = k_r;
          mem_wdata = k_links ? k_next_idx : END_MARK;
          if (k_r == K_LAST) begin
            heads_init     = 1'b1;
            res_load       = init_reply_r;
            init_reply_nxt = 1'b0;
            k_nxt          = '0;
            state_nxt      = S_IDLE;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
      end
      S_NOP: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      k_r          <= '0;
      init_reply_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      init_reply_r <= init_reply_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pool_r <= pool_nxt;
    stat_r <= stat_nxt;
    offs_r <= offs_nxt;
    if (accept) begin
      start_r <= in_req.block_address - ADDR_W'(hdr);
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
    end
    for (int p = 0; p < NPOOL; p++) begin
      if (heads_init) begin
        head_r[p] <= (g_cnt[p] != '0) ? g_first[p] : END_MARK;
      end else if (head_we && (head_sel == POOL_IW'(p))) begin
        head_r[p] <= head_wdata;
      end
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.granted_address = out_addr_r;

  `SCBPA_ASSERT_IMP(a_busy_blocks_input, state_r != S_IDLE, !in_req.ready,
                    "request accepted while an item is in flight")
  `SCBPA_ASSERT_IMP(a_fail_zero_addr, out_rsp.valid && (out_rsp.status != STAT_OK),
                    out_rsp.granted_address == '0, "failed result carries an address")
  `SCBPA_ASSERT_NXT(a_read_then_pop, rd_en, state_r == S_ALLOC,
                    "link read not followed by pop")
  `SCBPA_ASSERT_IMP(a_write_states, mem_we,
                    (state_r == S_ALLOC) || (state_r == S_FREE) || (state_r == S_INIT),
                    "link write outside alloc, free or init")

endmodule
